// File: src/aes_key_expansion_core_macros.svh
// ----------------------------------------------------------------------------
// aes key expansion core assertion macros
// shared assertion forms for the key expansion checker
// ----------------------------------------------------------------------------
`ifndef AES_KEY_EXPANSION_CORE_MACROS_SVH
`define AES_KEY_EXPANSION_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define AESKE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aes key expansion: same-cycle check failed");

// next-cycle implication, checked outside reset
`define AESKE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aes key expansion: next-cycle check failed");

`endif

// File: src/aeske_pkg.sv
// ----------------------------------------------------------------------------
// aes key expansion package
// key size codes, s-box table and word-level helpers
// ----------------------------------------------------------------------------
package aeske_pkg;

  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2
  } key_size_e;

  localparam int unsigned KeyWordW  = 32;
  localparam int unsigned SchedIdxW = 6;
  localparam int unsigned KeyIdxW   = 3;
  localparam int unsigned RoundW    = 4;

  localparam logic [KeyIdxW-1:0]   NkM1Key128   = 3'd3;
  localparam logic [KeyIdxW-1:0]   NkM1Key192   = 3'd5;
  localparam logic [KeyIdxW-1:0]   NkM1Key256   = 3'd7;
  localparam logic [SchedIdxW-1:0] LastIdx128   = 6'd43;
  localparam logic [SchedIdxW-1:0] LastIdx192   = 6'd51;
  localparam logic [SchedIdxW-1:0] LastIdx256   = 6'd59;
  localparam logic [KeyIdxW-1:0]   SubOnlySlot  = 3'd4;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [KeyWordW-1:0] sub_word(input logic [KeyWordW-1:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [KeyWordW-1:0] rot_word(input logic [KeyWordW-1:0] w);
    rot_word = {w[23:0], w[31:24]};
  endfunction

  // round constant for the word at round n (n counts from one)
  function automatic logic [7:0] rcon(input logic [RoundW-1:0] n);
    logic [7:0] r;
    r = 8'h36;
    case (n)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      default: r = 8'h36;
    endcase
    rcon = r;
  endfunction

endpackage

// File: src/aeske_ram.sv
// ----------------------------------------------------------------------------
// aes key expansion ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module aeske_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/aes_key_expansion_core.sv
// ----------------------------------------------------------------------------
// aes key expansion core
// stores 128, 192 or 256-bit keys word by word and streams the round-key
// schedule when the last key word is written
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------
//   key      | in        | start high, busy low      | key_word_i, key_word_index_i
//   schedule | out       | result_valid_o, one cycle | round_key_word_o,
//            |           |                           | schedule_index_o, last_word_o
//   config   | in/out    | apb write access phase    | key_size_sel at byte 0
//
// a key word that is not the last one for the key size is only stored
// the last key word starts 44, 52 or 60 schedule words, one per cycle; the
// first word trails the request; read issue, ram read and output register
// set the delay
// busy stays high until the last schedule word has been computed
// reset clears control state only; ram contents are undefined until written
// ----------------------------------------------------------------------------
module aes_key_expansion_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [aeske_pkg::KeyWordW-1:0]     key_word_i,
  input  logic [aeske_pkg::KeyIdxW-1:0]      key_word_index_i,
  output logic                               result_valid_o,
  output logic [aeske_pkg::KeyWordW-1:0]     round_key_word_o,
  output logic [aeske_pkg::SchedIdxW-1:0]    schedule_index_o,
  output logic                               last_word_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import aeske_pkg::*;

  logic [1:0]           key_size_sel_q;
  logic [KeyIdxW-1:0]   nk_m1;
  logic [SchedIdxW-1:0] last_idx;
  logic                 sub_only_en;

  logic                 req_acc;
  logic                 cfg_wr;

  logic                 iss_active_q, iss_active_d;
  logic [SchedIdxW-1:0] iss_idx_q, iss_idx_d;
  logic [KeyIdxW-1:0]   iss_slot_q, iss_slot_d;
  logic [RoundW-1:0]    iss_rnd_q, iss_rnd_d;

  logic                 c_valid_q;
  logic [SchedIdxW-1:0] c_idx_q;
  logic [KeyIdxW-1:0]   c_slot_q;
  logic [RoundW-1:0]    c_rnd_q;

  logic [KeyWordW-1:0]  prev_q;
  logic [KeyWordW-1:0]  key_rdata;
  logic [KeyWordW-1:0]  win_rdata;
  logic [KeyWordW-1:0]  word_d;

  logic                 out_valid_q;
  logic [KeyWordW-1:0]  out_word_q;
  logic [SchedIdxW-1:0] out_idx_q;
  logic                 out_last_q;

  always_comb begin
    unique case (key_size_sel_q)
      KEY_128: begin
        nk_m1    = NkM1Key128;
        last_idx = LastIdx128;
      end
      KEY_192: begin
        nk_m1    = NkM1Key192;
        last_idx = LastIdx192;
      end
      default: begin
        nk_m1    = NkM1Key256;
        last_idx = LastIdx256;
      end
    endcase
  end

  assign sub_only_en = (nk_m1 == NkM1Key256);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {30'd0, key_size_sel_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_sel_q <= KEY_128;
    end else if (cfg_wr) begin
      key_size_sel_q <= pwdata[1:0];
    end
  end

  // request side
  assign busy    = iss_active_q || c_valid_q;
  assign req_acc = start && !busy;

  // read issue counters
  always_comb begin
    iss_active_d = iss_active_q;
    iss_idx_d    = iss_idx_q;
    iss_slot_d   = iss_slot_q;
    iss_rnd_d    = iss_rnd_q;
    if (iss_active_q) begin
      iss_idx_d = iss_idx_q + 6'd1;
      if (iss_slot_q == nk_m1) begin
        iss_slot_d = '0;
        iss_rnd_d  = iss_rnd_q + 4'd1;
      end else begin
        iss_slot_d = iss_slot_q + 3'd1;
      end
      if (iss_idx_q == last_idx) begin
        iss_active_d = 1'b0;
      end
    end else if (req_acc && (key_word_index_i == nk_m1)) begin
      iss_active_d = 1'b1;
      iss_idx_d    = '0;
      iss_slot_d   = '0;
      iss_rnd_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_active_q <= 1'b0;
      iss_idx_q    <= '0;
      iss_slot_q   <= '0;
      iss_rnd_q    <= '0;
      c_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      iss_active_q <= iss_active_d;
      iss_idx_q    <= iss_idx_d;
      iss_slot_q   <= iss_slot_d;
      iss_rnd_q    <= iss_rnd_d;
      c_valid_q    <= iss_active_q;
      out_valid_q  <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_idx_q  <= iss_idx_q;
    c_slot_q <= iss_slot_q;
    c_rnd_q  <= iss_rnd_q;
  end

  // key store and sliding window of the last nk schedule words
  aeske_ram #(
    .Width(32),
    .Depth(8)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (req_acc),
    .waddr_i(key_word_index_i),
    .wdata_i(key_word_i),
    .raddr_i(iss_slot_q),
    .rdata_o(key_rdata)
  );

  aeske_ram #(
    .Width(32),
    .Depth(8)
  ) u_win_ram (
    .clk_i  (clk_i),
    .we_i   (c_valid_q),
    .waddr_i(c_slot_q),
    .wdata_i(word_d),
    .raddr_i(iss_slot_q),
    .rdata_o(win_rdata)
  );

  // schedule word; read and write slots of one cycle always differ
  always_comb begin
    priority if (c_rnd_q == '0) begin
      word_d = key_rdata;
    end else if (c_slot_q == '0) begin
      word_d = win_rdata ^ sub_word(rot_word(prev_q)) ^ {rcon(c_rnd_q), 24'd0};
    end else if (sub_only_en && (c_slot_q == SubOnlySlot)) begin
      word_d = win_rdata ^ sub_word(prev_q);
    end else begin
      word_d = win_rdata ^ prev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid_q) begin
      prev_q     <= word_d;
      out_word_q <= word_d;
      out_idx_q  <= c_idx_q;
      out_last_q <= (c_idx_q == last_idx);
    end
  end

  assign result_valid_o   = out_valid_q;
  assign round_key_word_o = out_word_q;
  assign schedule_index_o = out_idx_q;
  assign last_word_o      = out_valid_q && out_last_q;

endmodule

// File: src/aeske_checker.sv
// ----------------------------------------------------------------------------
// aes key expansion checker
// port-level checks on the schedule stream of the key expansion core
// ----------------------------------------------------------------------------
`include "aes_key_expansion_core_macros.svh"

module aeske_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        result_valid_o,
  input logic [5:0]  schedule_index_o,
  input logic        last_word_o
);

  logic mid_sched;
  logic len_ok;

  assign mid_sched = result_valid_o && !last_word_o;
  assign len_ok    = (schedule_index_o == 6'd43) || (schedule_index_o == 6'd51) ||
                     (schedule_index_o == 6'd59);

  // a schedule runs without gaps until its last word
  `AESKE_ASSERT_NEXT(a_stream_gapless, mid_sched, result_valid_o)

  // indices count up by one within a schedule
  `AESKE_ASSERT_NEXT(a_index_step, mid_sched, schedule_index_o == $past(schedule_index_o) + 6'd1)

  // a schedule ends at one of the three lengths
  `AESKE_ASSERT_NOW(a_last_len, result_valid_o && last_word_o, len_ok)

  // a schedule begins at index zero
  `AESKE_ASSERT_NOW(a_first_zero, $rose(result_valid_o), schedule_index_o == 6'd0)

  // the core is busy when the first word of a schedule appears
  `AESKE_ASSERT_NOW(a_busy_stream, result_valid_o && schedule_index_o == 6'd0, busy)

endmodule

bind aes_key_expansion_core aeske_checker u_aeske_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .busy            (busy),
  .result_valid_o  (result_valid_o),
  .schedule_index_o(schedule_index_o),
  .last_word_o     (last_word_o)
);
